### rtl/core/sma_pkg.sv
// Package for the stack machine execution unit: transaction types, codes and constants.
// Depends on nothing; every module of the unit imports it.
package sma_pkg;

   localparam int STACK_DEPTH_DEF = 64;
   localparam int REG_COUNT_DEF   = 8;

   typedef enum logic [3:0] {
      FUNC_PUSH    = 4'd0,
      FUNC_ADD     = 4'd1,
      FUNC_SUB     = 4'd2,
      FUNC_MUL     = 4'd3,
      FUNC_DIV     = 4'd4,
      FUNC_SQRT    = 4'd5,
      FUNC_OUT     = 4'd6,
      FUNC_POP_REG = 4'd7,
      FUNC_PSH_REG = 4'd8
   } func_type;

   typedef enum logic [2:0] {
      ST_OK      = 3'd0,
      ST_UNDER   = 3'd1,
      ST_OVER    = 3'd2,
      ST_DIVZERO = 3'd3,
      ST_BADREG  = 3'd4,
      ST_NEGSQRT = 3'd5
   } status_type;

   typedef struct packed {
      logic [3:0]         func;
      logic signed [31:0] value;
      logic [3:0]         reg_index;
   } req_type;

   typedef struct packed {
      logic [2:0]         status;
      logic               out_valid;
      logic signed [31:0] out_value;
      logic [6:0]         stack_depth;
   } rsp_type;

   typedef struct packed {
      logic        start;
      logic        is_sqrt;
      logic [31:0] a;
      logic [31:0] b;
   } itu_cmd_type;

   typedef struct packed {
      logic        done;
      logic [31:0] result;
   } itu_res_type;

endpackage

### rtl/core/sma_iter.sv
// Iterative unit for the stack machine: signed truncating division and floor square root.
// One bit of the result per cycle. Uses sma_pkg.
module sma_iter (
   input  logic                 clock,
   input  logic                 reset,
   input  sma_pkg::itu_cmd_type cmd,
   output sma_pkg::itu_res_type res
);
   import sma_pkg::*;

   logic [5:0]  count_ff, count_in;
   logic        busy_ff, busy_in;
   logic        sqrt_ff, sqrt_in;
   logic        neg_ff, neg_in;
   logic [31:0] num_ff, num_in;
   logic [31:0] den_ff, den_in;
   logic [33:0] rem_ff, rem_in;
   logic [31:0] quo_ff, quo_in;
   logic        done_ff, done_in;

   logic [33:0] rem_sh;
   logic [33:0] trial;

   always_comb begin
      count_in = count_ff;
      busy_in  = busy_ff;
      sqrt_in  = sqrt_ff;
      neg_in   = neg_ff;
      num_in   = num_ff;
      den_in   = den_ff;
      rem_in   = rem_ff;
      quo_in   = quo_ff;
      done_in  = 1'b0;
      rem_sh   = '0;
      trial    = '0;
      if (cmd.start) begin
         busy_in  = 1'b1;
         count_in = '0;
         sqrt_in  = cmd.is_sqrt;
         neg_in   = cmd.a[31] ^ cmd.b[31];
         num_in   = (cmd.a[31] && !cmd.is_sqrt) ? (32'd0 - cmd.a) : cmd.a;
         den_in   = cmd.b[31] ? (32'd0 - cmd.b) : cmd.b;
         rem_in   = '0;
         quo_in   = '0;
      end else if (busy_ff) begin
         if (sqrt_ff) begin
            rem_sh = {rem_ff[31:0], num_ff[31:30]};
            trial  = {quo_ff, 2'b01};
            num_in = {num_ff[29:0], 2'b00};
            if (rem_sh >= trial) begin
               rem_in = rem_sh - trial;
               quo_in = {quo_ff[30:0], 1'b1};
            end else begin
               rem_in = rem_sh;
               quo_in = {quo_ff[30:0], 1'b0};
            end
            if (count_ff == 6'd15) begin
               busy_in = 1'b0;
               done_in = 1'b1;
            end
         end else begin
            rem_sh = {rem_ff[32:0], num_ff[31]};
            trial  = {2'b00, den_ff};
            num_in = {num_ff[30:0], 1'b0};
            if (rem_sh >= trial) begin
               rem_in = rem_sh - trial;
               quo_in = {quo_ff[30:0], 1'b1};
            end else begin
               rem_in = rem_sh;
               quo_in = {quo_ff[30:0], 1'b0};
            end
            if (count_ff == 6'd31) begin
               busy_in = 1'b0;
               done_in = 1'b1;
            end
         end
         count_in = count_ff + 6'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      count_ff <= count_in;
      sqrt_ff  <= sqrt_in;
      neg_ff   <= neg_in;
      num_ff   <= num_in;
      den_ff   <= den_in;
      rem_ff   <= rem_in;
      quo_ff   <= quo_in;
   end

   assign res.done   = done_ff;
   assign res.result = (neg_ff && !sqrt_ff) ? (32'd0 - quo_ff) : quo_ff;

endmodule

### rtl/core/stack_machine_alu.sv
// Channel | Direction | Handshake           | Payload
// req     | in        | req_valid/req_stall | sma_pkg::req_type
// rsp     | out       | rsp_valid/rsp_stall | sma_pkg::rsp_type
// One transaction at a time. Every request passes S_RD1 and then ends in S_RESP. Push,
// push register and a short or full stack go from S_RD1 straight to S_RESP; out, pop
// register and negative square root pass S_EXEC; add, sub, multiply and divide pass S_RD2
// and S_EXEC, multiply then S_MUL; divide and square root wait in S_ITER (32 or 16 steps).
// Synchronous reset empties the stack and clears the registers; no clearing pass.
// A stalled response holds; the next transaction is taken once the response leaves.
// Top level of the stack machine execution unit; uses sma_pkg and sma_iter.
module stack_machine_alu #(
   parameter int STACK_DEPTH = sma_pkg::STACK_DEPTH_DEF,
   parameter int REG_COUNT   = sma_pkg::REG_COUNT_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  sma_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output sma_pkg::rsp_type rsp_data
);
   import sma_pkg::*;

   localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
   localparam int SW = $clog2(STACK_DEPTH + 1);
   localparam int RW = (REG_COUNT > 1) ? $clog2(REG_COUNT) : 1;

   typedef enum logic [6:0] {
      S_IDLE = 7'b0000001,
      S_RD1  = 7'b0000010,
      S_RD2  = 7'b0000100,
      S_EXEC = 7'b0001000,
      S_MUL  = 7'b0010000,
      S_ITER = 7'b0100000,
      S_RESP = 7'b1000000
   } state_type;

   logic [31:0] stack_mem [STACK_DEPTH];
   logic [31:0] rd_data_ff;
   logic [AW-1:0] rd_addr;
   logic          wr_en;
   logic [AW-1:0] wr_addr;
   logic [31:0]   wr_data;

   logic [31:0] regs_ff [REG_COUNT];
   logic        reg_wr;

   state_type   state_ff, state_in;
   logic [SW-1:0] sp_ff, sp_in;
   req_type     req_ff;
   logic [31:0] right_ff, right_in;
   logic [31:0] prod_ff;
   rsp_type     rsp_ff, rsp_in;
   logic        rsp_valid_ff, rsp_valid_in;
   itu_cmd_type cmd;
   itu_res_type ires;
   logic        reg_bad;
   logic [RW-1:0] ridx;

   assign reg_bad = {28'd0, req_ff.reg_index} >= REG_COUNT;
   assign ridx    = req_ff.reg_index[RW-1:0];

   sma_iter u_iter (.clock(clock), .reset(reset), .cmd(cmd), .res(ires));

   always_comb begin
      state_in     = state_ff;
      sp_in        = sp_ff;
      right_in     = right_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff;
      rd_addr      = AW'(sp_ff - SW'(1));
      wr_en        = 1'b0;
      wr_addr      = sp_ff[AW-1:0];
      wr_data      = req_ff.value;
      reg_wr       = 1'b0;
      cmd          = '0;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               state_in = S_RD1;
            end
         end
         S_RD1: begin
            rsp_in           = '0;
            rsp_in.status    = ST_OK;
            state_in         = S_RESP;
            rsp_valid_in     = 1'b1;
            case (req_ff.func)
               FUNC_PUSH: begin
                  if ({{(32-SW){1'b0}}, sp_ff} >= STACK_DEPTH) begin
                     rsp_in.status = ST_OVER;
                  end else begin
                     wr_en = 1'b1;
                     sp_in = sp_ff + SW'(1);
                  end
               end
               FUNC_PSH_REG: begin
                  if (reg_bad) begin
                     rsp_in.status = ST_BADREG;
                  end else if ({{(32-SW){1'b0}}, sp_ff} >= STACK_DEPTH) begin
                     rsp_in.status = ST_OVER;
                  end else begin
                     wr_en   = 1'b1;
                     wr_data = regs_ff[ridx];
                     sp_in   = sp_ff + SW'(1);
                  end
               end
               FUNC_ADD, FUNC_SUB, FUNC_MUL, FUNC_DIV: begin
                  if (sp_ff < SW'(2)) begin
                     rsp_in.status = ST_UNDER;
                  end else begin
                     right_in     = rd_data_ff;
                     rd_addr      = AW'(sp_ff - SW'(2));
                     state_in     = S_RD2;
                     rsp_valid_in = 1'b0;
                  end
               end
               FUNC_SQRT, FUNC_OUT, FUNC_POP_REG: begin
                  if (sp_ff == '0) begin
                     if (req_ff.func == FUNC_SQRT) begin
                        rsp_in.status = ST_UNDER;
                     end
                  end else begin
                     state_in     = S_EXEC;
                     rsp_valid_in = 1'b0;
                  end
               end
               default: begin
               end
            endcase
         end
         S_RD2: begin
            rd_addr  = AW'(sp_ff - SW'(2));
            state_in = S_EXEC;
         end
         S_EXEC: begin
            state_in     = S_RESP;
            rsp_valid_in = 1'b1;
            case (req_ff.func)
               FUNC_ADD, FUNC_SUB: begin
                  wr_addr = AW'(sp_ff - SW'(2));
                  wr_data = (req_ff.func == FUNC_ADD) ? rd_data_ff + right_ff
                                                      : rd_data_ff - right_ff;
                  wr_en   = 1'b1;
                  sp_in   = sp_ff - SW'(1);
               end
               FUNC_MUL: begin
                  state_in     = S_MUL;
                  rsp_valid_in = 1'b0;
               end
               FUNC_DIV: begin
                  if (right_ff == '0) begin
                     rsp_in.status = ST_DIVZERO;
                     sp_in         = sp_ff - SW'(2);
                  end else begin
                     cmd.start    = 1'b1;
                     cmd.a        = rd_data_ff;
                     cmd.b        = right_ff;
                     state_in     = S_ITER;
                     rsp_valid_in = 1'b0;
                  end
               end
               FUNC_SQRT: begin
                  if (rd_data_ff[31]) begin
                     rsp_in.status = ST_NEGSQRT;
                     sp_in         = sp_ff - SW'(1);
                  end else begin
                     cmd.start    = 1'b1;
                     cmd.is_sqrt  = 1'b1;
                     cmd.a        = rd_data_ff;
                     state_in     = S_ITER;
                     rsp_valid_in = 1'b0;
                  end
               end
               FUNC_OUT: begin
                  rsp_in.out_valid = 1'b1;
                  rsp_in.out_value = rd_data_ff;
                  sp_in            = sp_ff - SW'(1);
               end
               default: begin
                  sp_in = sp_ff - SW'(1);
                  if (reg_bad) begin
                     rsp_in.status = ST_BADREG;
                  end else begin
                     reg_wr = 1'b1;
                  end
               end
            endcase
         end
         S_MUL: begin
            wr_addr      = AW'(sp_ff - SW'(2));
            wr_data      = prod_ff;
            wr_en        = 1'b1;
            sp_in        = sp_ff - SW'(1);
            state_in     = S_RESP;
            rsp_valid_in = 1'b1;
         end
         S_ITER: begin
            if (ires.done) begin
               wr_data      = ires.result;
               wr_en        = 1'b1;
               state_in     = S_RESP;
               rsp_valid_in = 1'b1;
               if (req_ff.func == FUNC_DIV) begin
                  wr_addr = AW'(sp_ff - SW'(2));
                  sp_in   = sp_ff - SW'(1);
               end else begin
                  wr_addr = AW'(sp_ff - SW'(1));
               end
            end
         end
         S_RESP: begin
            if (!rsp_stall) begin
               rsp_valid_in = 1'b0;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
      rsp_in.stack_depth = 7'(sp_in);
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         stack_mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= stack_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         sp_ff        <= '0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < REG_COUNT; i++) begin
            regs_ff[i] <= '0;
         end
      end else begin
         state_ff     <= state_in;
         sp_ff        <= sp_in;
         rsp_valid_ff <= rsp_valid_in;
         if (reg_wr) begin
            regs_ff[ridx] <= rd_data_ff;
         end
      end
      if (state_ff == S_IDLE && req_valid) begin
         req_ff <= req_data;
      end
      right_ff <= right_in;
      rsp_ff   <= rsp_in;
      prod_ff  <= rd_data_ff * right_ff;
   end

   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

### rtl/core/sma_checker.sv
// Port checker for the stack machine execution unit, bound to stack_machine_alu.
// Uses sma_pkg for the transaction types and status codes.
module sma_checker (
   input logic             clock,
   input logic             reset,
   input logic             req_valid,
   input logic             req_stall,
   input logic             rsp_valid,
   input logic             rsp_stall,
   input sma_pkg::rsp_type rsp_data
);
   import sma_pkg::*;

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("Stalled response changed.");

   a_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> req_stall)
      else $error("Request taken while a response is pending.");

   a_out_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.out_valid |-> rsp_data.status == ST_OK)
      else $error("Output value with error status.");

   a_one_rsp: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> !rsp_valid)
      else $error("Response appeared without work.");

endmodule

bind stack_machine_alu sma_checker u_sma_checker (
   .clock(clock), .reset(reset), .req_valid(req_valid), .req_stall(req_stall),
   .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data)
);
